>>> rtl/i2c_register_byte_master_top_defines.svh
// ----------------------------------------------------------------------------
// I2C register byte master: assertion macros
// Shared helpers for the concurrent checks on the master's ports.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_BYTE_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_BYTE_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define I2CRBM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define I2CRBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/i2crbm_pkg.sv
// ----------------------------------------------------------------------------
// I2C register byte master package
// Action codes and sequencer phase codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2crbm_pkg;

  localparam int unsigned AddrW  = 7;
  localparam int unsigned GapW   = 4;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned PhaseW = 6;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_GAP      = 1'b1;

  localparam logic [PhaseW-1:0] PH_IDLE       = 6'd0;
  localparam logic [PhaseW-1:0] PH_TX_AW      = 6'd1;
  localparam logic [PhaseW-1:0] PH_ACK_AW_LO  = 6'd2;
  localparam logic [PhaseW-1:0] PH_ACK_AW_HI  = 6'd3;
  localparam logic [PhaseW-1:0] PH_TX_IDX     = 6'd4;
  localparam logic [PhaseW-1:0] PH_ACK_IDX_LO = 6'd5;
  localparam logic [PhaseW-1:0] PH_ACK_IDX_HI = 6'd6;
  localparam logic [PhaseW-1:0] PH_TX_DAT     = 6'd7;
  localparam logic [PhaseW-1:0] PH_ACK_DAT_LO = 6'd8;
  localparam logic [PhaseW-1:0] PH_ACK_DAT_HI = 6'd9;
  localparam logic [PhaseW-1:0] PH_GAP        = 6'd10;
  localparam logic [PhaseW-1:0] PH_START2     = 6'd11;
  localparam logic [PhaseW-1:0] PH_TX_AR      = 6'd12;
  localparam logic [PhaseW-1:0] PH_ACK_AR_LO  = 6'd13;
  localparam logic [PhaseW-1:0] PH_ACK_AR_HI  = 6'd14;
  localparam logic [PhaseW-1:0] PH_RX         = 6'd15;
  localparam logic [PhaseW-1:0] PH_MNACK_LO   = 6'd16;
  localparam logic [PhaseW-1:0] PH_MNACK_HI   = 6'd17;
  localparam logic [PhaseW-1:0] PH_STOP_OK0   = 6'd18;
  localparam logic [PhaseW-1:0] PH_STOP_OK1   = 6'd19;
  localparam logic [PhaseW-1:0] PH_STOP_OK2   = 6'd20;
  localparam logic [PhaseW-1:0] PH_STOP_NK0   = 6'd21;
  localparam logic [PhaseW-1:0] PH_STOP_NK1   = 6'd22;
  localparam logic [PhaseW-1:0] PH_STOP_NK2   = 6'd23;
  localparam logic [PhaseW-1:0] PH_STOP_MID0  = 6'd24;
  localparam logic [PhaseW-1:0] PH_STOP_MID1  = 6'd25;
  localparam logic [PhaseW-1:0] PH_STOP_MID2  = 6'd26;

  localparam logic [AddrW-1:0] DEV_ADDR_RST = 7'd111;
  localparam logic [GapW-1:0]  GAP_RST      = 4'd3;

endpackage

`default_nettype wire

>>> rtl/i2c_register_byte_master_top.sv
// The result of an accepted slot transaction is on the output register in the next cycle.
// One slot per cycle while in_stall_o is low; the bus sequencer advances once per accepted slot.
// The output register releases the input side whenever it is empty or being drained.
// Reset (rst_ni low, asynchronous): sequencer idle, counters and shift byte cleared,
// received byte zero, device address 111, session gap 3, output register empty.
// ----------------------------------------------------------------------------
// I2C register byte master
// Slot-driven I2C master for single-byte register writes and reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_byte_master_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [i2crbm_pkg::CfgW-1:0] cfg_wdata_i,
  // slot input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       sda_in_i,
  // slot result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic            sda_drive_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic            nack_o,
  output logic [7:0]      read_data_o
);
  import i2crbm_pkg::*;

  // Configuration registers
  logic [AddrW-1:0]  dev_addr_q;
  logic [GapW-1:0]   gap_slots_q;

  // Sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic              is_read_q, is_read_d;
  logic [7:0]        held_idx_q, held_idx_d;
  logic [7:0]        held_dat_q, held_dat_d;
  logic [GapW-1:0]   gap_cnt_q, gap_cnt_d;
  logic [7:0]        rx_byte_q, rx_byte_d;

  // Slot outputs before the result register
  logic scl, sda, drv, busy, done, nk;
  logic half;

  // Output register
  logic       out_valid_q;
  logic       scl_q, sda_q, drv_q, busy_q, done_q, nk_q;
  logic [7:0] rdata_q;

  logic accept;

  // A transaction enters whenever the result register is free or drains now.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DEV_ADDR_RST;
      gap_slots_q <= GAP_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DEV_ADDR) begin
        dev_addr_q <= cfg_wdata_i[AddrW-1:0];
      end else begin
        gap_slots_q <= cfg_wdata_i[GapW-1:0];
      end
    end
  end

  assign half = bit_cnt_q[0];

  // One bus slot: outputs of this slot and the state for the next one.
  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    is_read_d  = is_read_q;
    held_idx_d = held_idx_q;
    held_dat_d = held_dat_q;
    gap_cnt_d  = gap_cnt_q;
    rx_byte_d  = rx_byte_q;
    scl  = 1'b1;
    sda  = 1'b1;
    drv  = 1'b0;
    busy = 1'b1;
    done = 1'b0;
    nk   = 1'b0;

    case (phase_q)
      PH_TX_AW, PH_TX_IDX, PH_TX_DAT, PH_TX_AR: begin
        // each bit: SCL low slot then SCL high slot, MSB first
        scl = half;
        sda = shift_q[7];
        drv = 1'b1;
        if (half) begin
          shift_d = {shift_q[6:0], 1'b0};
        end
        if (bit_cnt_q == 4'd15) begin
          bit_cnt_d = 4'd0;
          phase_d   = phase_q + 6'd1;
        end else begin
          bit_cnt_d = bit_cnt_q + 4'd1;
        end
      end
      PH_ACK_AW_LO, PH_ACK_IDX_LO, PH_ACK_DAT_LO, PH_ACK_AR_LO: begin
        scl     = 1'b0;
        phase_d = phase_q + 6'd1;
      end
      PH_ACK_AW_HI, PH_ACK_IDX_HI, PH_ACK_DAT_HI, PH_ACK_AR_HI: begin
        // target ACK sampled with SDA released; high level is a NACK
        bit_cnt_d = 4'd0;
        if (sda_in_i) begin
          phase_d = PH_STOP_NK0;
        end else if (phase_q == PH_ACK_AW_HI) begin
          shift_d = held_idx_q;
          phase_d = PH_TX_IDX;
        end else if (phase_q == PH_ACK_IDX_HI) begin
          if (is_read_q) begin
            phase_d = PH_STOP_MID0;
          end else begin
            shift_d = held_dat_q;
            phase_d = PH_TX_DAT;
          end
        end else if (phase_q == PH_ACK_DAT_HI) begin
          phase_d = PH_STOP_OK0;
        end else begin
          shift_d = 8'd0;
          phase_d = PH_RX;
        end
      end
      PH_RX: begin
        scl = half;
        if (half) begin
          shift_d = {shift_q[6:0], sda_in_i};
        end
        if (bit_cnt_q == 4'd15) begin
          bit_cnt_d = 4'd0;
          phase_d   = PH_MNACK_LO;
        end else begin
          bit_cnt_d = bit_cnt_q + 4'd1;
        end
      end
      PH_MNACK_LO: begin
        scl     = 1'b0;
        drv     = 1'b1;
        phase_d = PH_MNACK_HI;
      end
      PH_MNACK_HI: begin
        drv     = 1'b1;
        phase_d = PH_STOP_OK0;
      end
      PH_STOP_OK0, PH_STOP_NK0, PH_STOP_MID0: begin
        scl     = 1'b0;
        sda     = 1'b0;
        drv     = 1'b1;
        phase_d = phase_q + 6'd1;
      end
      PH_STOP_OK1, PH_STOP_NK1, PH_STOP_MID1: begin
        sda     = 1'b0;
        drv     = 1'b1;
        phase_d = phase_q + 6'd1;
      end
      PH_STOP_OK2, PH_STOP_NK2: begin
        done    = 1'b1;
        nk      = (phase_q == PH_STOP_NK2);
        phase_d = PH_IDLE;
        if (!nk && is_read_q) begin
          rx_byte_d = shift_q;
        end
      end
      PH_STOP_MID2: begin
        if (gap_slots_q == '0) begin
          phase_d = PH_START2;
        end else begin
          gap_cnt_d = gap_slots_q - 4'd1;
          phase_d   = PH_GAP;
        end
      end
      PH_GAP: begin
        if (gap_cnt_q == '0) begin
          phase_d = PH_START2;
        end else begin
          gap_cnt_d = gap_cnt_q - 4'd1;
        end
      end
      PH_START2: begin
        sda       = 1'b0;
        drv       = 1'b1;
        shift_d   = {dev_addr_q, 1'b1};
        bit_cnt_d = 4'd0;
        phase_d   = PH_TX_AR;
      end
      default: begin
        // idle; unused codes fall back to idle
        phase_d = PH_IDLE;
        if (action_i == ACT_WRITE || action_i == ACT_READ) begin
          sda        = 1'b0;
          drv        = 1'b1;
          is_read_d  = (action_i == ACT_READ);
          held_idx_d = reg_index_i;
          held_dat_d = write_data_i;
          shift_d    = {dev_addr_q, 1'b0};
          bit_cnt_d  = 4'd0;
          phase_d    = PH_TX_AW;
        end else begin
          busy = 1'b0;
        end
      end
    endcase

    // released SDA reads as the pulled-up level
    if (!drv) begin
      sda = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      is_read_q  <= 1'b0;
      held_idx_q <= '0;
      held_dat_q <= '0;
      gap_cnt_q  <= '0;
      rx_byte_q  <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      is_read_q  <= is_read_d;
      held_idx_q <= held_idx_d;
      held_dat_q <= held_dat_d;
      gap_cnt_q  <= gap_cnt_d;
      rx_byte_q  <= rx_byte_d;
    end
  end

  // Result register: holds while stalled, reloads on every accepted slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      scl_q   <= scl;
      sda_q   <= sda;
      drv_q   <= drv;
      busy_q  <= busy;
      done_q  <= done;
      nk_q    <= nk;
      rdata_q <= rx_byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = scl_q;
  assign sda_level_o = sda_q;
  assign sda_drive_o = drv_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign nack_o      = nk_q;
  assign read_data_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/i2crbm_chk.sv
// ----------------------------------------------------------------------------
// I2C register byte master checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_byte_master_top_defines.svh"

module i2crbm_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       scl_level_o,
  input wire logic       sda_level_o,
  input wire logic       sda_drive_o,
  input wire logic       busy_res_o,
  input wire logic       done_res_o,
  input wire logic       nack_o,
  input wire logic [7:0] read_data_o
);

  `I2CRBM_ASSERT(a_released_high, out_valid_o && !sda_drive_o, sda_level_o, "released SDA not high")
  `I2CRBM_ASSERT(a_done_busy, out_valid_o && done_res_o, busy_res_o && scl_level_o && !sda_drive_o, "done outside a final STOP slot")
  `I2CRBM_ASSERT(a_nack_done, out_valid_o && nack_o, done_res_o, "nack without done")
  `I2CRBM_ASSERT(a_idle_bus, out_valid_o && !busy_res_o, scl_level_o && !sda_drive_o, "idle slot drives the bus")
  `I2CRBM_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o) && $stable(scl_level_o), "stalled result changed")

endmodule

bind i2c_register_byte_master_top i2crbm_chk u_i2crbm_chk (.*);

`default_nettype wire

>>> dv/i2crbm_bus_checker.sv
// ----------------------------------------------------------------------------
// I2C register byte master: slot checker
// Watches both slot channels and the register port, predicts each slot result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2crbm_bus_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       sda_in_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic       scl_level_i,
  input  wire logic       sda_level_i,
  input  wire logic       sda_drive_i,
  input  wire logic       busy_res_i,
  input  wire logic       done_res_i,
  input  wire logic       nack_i,
  input  wire logic [7:0] read_data_i,
  output int unsigned     errors_o,
  output int unsigned     pending_o
);
  import i2crbm_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic       nack;
    logic [7:0] rdata;
  } slot_res_t;

  slot_res_t slot_exp_q[$];
  int unsigned err_cnt;

  // bus sequencer copy
  logic [PhaseW-1:0] bus_phase;
  logic [3:0]        bit_cnt;
  logic [7:0]        shreg;
  logic              is_rd;
  logic [7:0]        held_idx;
  logic [7:0]        held_dat;
  logic [3:0]        gap_cnt;
  logic [7:0]        rx_byte;
  logic [AddrW-1:0]  dev_addr;
  logic [GapW-1:0]   gap_cfg;

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ERROR: %s expected %0h got %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // one bus slot: advance the sequencer and form the slot's levels
  task automatic step_bus(input logic [1:0] act, input logic [7:0] idx,
                          input logic [7:0] dat, input logic line,
                          output slot_res_t res);
    logic half;
    logic scl, sda, drv, busy, done, nk;
    half = bit_cnt[0];
    scl  = 1'b1;
    sda  = 1'b1;
    drv  = 1'b0;
    busy = 1'b1;
    done = 1'b0;
    nk   = 1'b0;
    case (bus_phase)
      PH_TX_AW, PH_TX_IDX, PH_TX_DAT, PH_TX_AR: begin
        scl = half;
        sda = shreg[7];
        drv = 1'b1;
        if (half) shreg = shreg << 1;
        if (bit_cnt == 4'd15) begin
          bit_cnt   = '0;
          bus_phase = bus_phase + 1'b1;
        end else begin
          bit_cnt = bit_cnt + 1'b1;
        end
      end
      PH_ACK_AW_LO, PH_ACK_IDX_LO, PH_ACK_DAT_LO, PH_ACK_AR_LO: begin
        scl       = 1'b0;
        bus_phase = bus_phase + 1'b1;
      end
      PH_ACK_AW_HI, PH_ACK_IDX_HI, PH_ACK_DAT_HI, PH_ACK_AR_HI: begin
        if (line) begin
          bus_phase = PH_STOP_NK0;
        end else begin
          case (bus_phase)
            PH_ACK_AW_HI: begin
              shreg     = held_idx;
              bus_phase = PH_TX_IDX;
            end
            PH_ACK_IDX_HI: begin
              if (is_rd) begin
                bus_phase = PH_STOP_MID0;
              end else begin
                shreg     = held_dat;
                bus_phase = PH_TX_DAT;
              end
            end
            PH_ACK_DAT_HI: bus_phase = PH_STOP_OK0;
            default: begin
              shreg     = '0;
              bus_phase = PH_RX;
            end
          endcase
        end
        bit_cnt = '0;
      end
      PH_RX: begin
        scl = half;
        if (half) shreg = {shreg[6:0], line};
        if (bit_cnt == 4'd15) begin
          bit_cnt   = '0;
          bus_phase = PH_MNACK_LO;
        end else begin
          bit_cnt = bit_cnt + 1'b1;
        end
      end
      PH_MNACK_LO: begin
        scl       = 1'b0;
        drv       = 1'b1;
        bus_phase = PH_MNACK_HI;
      end
      PH_MNACK_HI: begin
        drv       = 1'b1;
        bus_phase = PH_STOP_OK0;
      end
      PH_STOP_OK0, PH_STOP_NK0, PH_STOP_MID0: begin
        scl       = 1'b0;
        sda       = 1'b0;
        drv       = 1'b1;
        bus_phase = bus_phase + 1'b1;
      end
      PH_STOP_OK1, PH_STOP_NK1, PH_STOP_MID1: begin
        sda       = 1'b0;
        drv       = 1'b1;
        bus_phase = bus_phase + 1'b1;
      end
      PH_STOP_MID2: begin
        if (gap_cfg == '0) begin
          bus_phase = PH_START2;
        end else begin
          gap_cnt   = gap_cfg - 1'b1;
          bus_phase = PH_GAP;
        end
      end
      PH_STOP_OK2: begin
        done = 1'b1;
        if (is_rd) rx_byte = shreg;
        bus_phase = PH_IDLE;
      end
      PH_STOP_NK2: begin
        done      = 1'b1;
        nk        = 1'b1;
        bus_phase = PH_IDLE;
      end
      PH_GAP: begin
        if (gap_cnt == '0) bus_phase = PH_START2;
        else gap_cnt = gap_cnt - 1'b1;
      end
      PH_START2: begin
        sda       = 1'b0;
        drv       = 1'b1;
        shreg     = {dev_addr, 1'b1};
        bit_cnt   = '0;
        bus_phase = PH_TX_AR;
      end
      default: begin
        bus_phase = PH_IDLE;
        if (act == ACT_WRITE || act == ACT_READ) begin
          sda       = 1'b0;
          drv       = 1'b1;
          is_rd     = (act == ACT_READ);
          held_idx  = idx;
          held_dat  = dat;
          shreg     = {dev_addr, 1'b0};
          bit_cnt   = '0;
          bus_phase = PH_TX_AW;
        end else begin
          busy = 1'b0;
        end
      end
    endcase
    if (!drv) sda = 1'b1;   // released line reads back as pulled up
    res = '{scl, sda, drv, busy, done, nk, rx_byte};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_res_t got;
    slot_res_t want;
    if (!rst_ni) begin
      bus_phase = PH_IDLE;
      bit_cnt   = '0;
      shreg     = '0;
      is_rd     = 1'b0;
      held_idx  = '0;
      held_dat  = '0;
      gap_cnt   = '0;
      rx_byte   = '0;
      dev_addr  = 7'd111;
      gap_cfg   = 4'd3;
      err_cnt   = 0;
      slot_exp_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{scl_level_i, sda_level_i, sda_drive_i, busy_res_i, done_res_i,
                nack_i, read_data_i};
        if (slot_exp_q.size() == 0) begin
          $display("%0t ERROR: slot result with none expected, got %0h", $time, got);
          err_cnt++;
        end else begin
          want = slot_exp_q.pop_front();
          check_field("scl_level", 8'(want.scl), 8'(got.scl));
          check_field("sda_level", 8'(want.sda), 8'(got.sda));
          check_field("sda_drive", 8'(want.drv), 8'(got.drv));
          check_field("busy_res", 8'(want.busy), 8'(got.busy));
          check_field("done_res", 8'(want.done), 8'(got.done));
          check_field("nack", 8'(want.nack), 8'(got.nack));
          check_field("read_data", want.rdata, got.rdata);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_bus(action_i, reg_index_i, write_data_i, sda_in_i, want);
        slot_exp_q.push_back(want);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DEV_ADDR) dev_addr = cfg_wdata_i[AddrW-1:0];
        else gap_cfg = cfg_wdata_i[GapW-1:0];
      end
      errors_o  <= err_cnt;
      pending_o <= slot_exp_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// I2C register byte master testbench
// Drives whole write and read transactions slot by slot, with a modeled target
// answering ACK, NACK and read bits; random noise, idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import i2crbm_pkg::*;

  // action code the block treats as a plain tick
  localparam logic [1:0] ACT_SPARE = 2'd3;
  // ack index meaning "target acknowledges every byte"
  localparam int NO_NACK = 3;
  // ticks with SDA high that bring the block back to idle from any phase
  localparam int RESYNC_SLOTS = 48;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = ACT_TICK;
  logic [7:0] reg_index = '0;
  logic [7:0] write_data = '0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level, sda_level, sda_drive, busy_res, done_res, nack;
  logic [7:0] read_data;

  int unsigned errors, pending;
  int unsigned cycles = 0;
  int unsigned slots_sent = 0;
  int          burst_left = 0;
  logic [3:0]  cur_gap = 4'd3;   // gap setting the sequencer runs with
  bit          hold_req = 1'b0;

  always #4 clk = ~clk;

  i2c_register_byte_master_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .sda_in_i     (sda_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .scl_level_o  (scl_level),
    .sda_level_o  (sda_level),
    .sda_drive_o  (sda_drive),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .nack_o       (nack),
    .read_data_o  (read_data)
  );

  i2crbm_bus_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .sda_in_i     (sda_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .scl_level_i  (scl_level),
    .sda_level_i  (sda_level),
    .sda_drive_i  (sda_drive),
    .busy_res_i   (busy_res),
    .done_res_i   (done_res),
    .nack_i       (nack),
    .read_data_i  (read_data),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Bytes lean toward all-zeros and all-ones so both extremes show up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one slot transaction and hold it until accepted. The sender runs in
  // bursts; between bursts valid drops unless the drawn pause is zero. Valid is
  // raised or lowered only here and in drain_bus, once per time step, and never looks at stall.
  task automatic send_slot(input logic [1:0] act, input logic [7:0] idx,
                           input logic [7:0] dat, input logic line);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      gap        = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    action     <= act;
    reg_index  <= idx;
    write_data <= dat;
    sda_in     <= line;
    do @(posedge clk); while (in_stall);
    burst_left--;
    slots_sent++;
    if (slots_sent == 300) hold_req = 1'b1;
  endtask

  // A slot where the block is busy: the action is junk (starts get ignored)
  // and SDA is whatever the target happens to leave, unless the caller cares.
  task automatic busy_slot(input logic line);
    send_slot(2'($urandom), 8'($urandom), 8'($urandom), line);
  endtask

  // One full register transaction as the bus sees it. nack_at picks which
  // acknowledge the target refuses: 0 address, 1 index, 2 data (write) or
  // address+R (read); NO_NACK for a clean run. rx is the byte the target
  // returns on a read.
  task automatic run_transfer(input bit rd, input logic [7:0] idx,
                              input logic [7:0] dat, input logic [7:0] rx,
                              input int nack_at);
    int k;
    int i;
    send_slot(rd ? ACT_READ : ACT_WRITE, idx, dat, 1'($urandom));
    for (k = 0; k < 3; k++) begin
      // read: STOP of the pointer session, the idle gap, then repeated START
      if (rd && k == 2) repeat (3 + cur_gap + 1) busy_slot(1'($urandom));
      repeat (17) busy_slot(1'($urandom));   // eight bits plus ack low half
      busy_slot(k == nack_at);               // ack high half, SDA sampled
      if (k == nack_at) begin
        repeat (3) busy_slot(1'($urandom));  // STOP after the refusal
        return;
      end
    end
    if (rd) begin
      for (i = 7; i >= 0; i--) begin
        busy_slot(1'($urandom));
        busy_slot(rx[i]);                    // target data, MSB first
      end
      repeat (2) busy_slot(1'($urandom));    // master NACK
    end
    repeat (3) busy_slot(1'($urandom));      // STOP
  endtask

  // Let everything in flight come out, then a few spare cycles so the block
  // is surely idle before registers change or the run ends.
  task automatic drain_bus();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers back to back; the gap write carries junk upper bits.
  task automatic program_bus(input logic [6:0] addr, input logic [3:0] gap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEV_ADDR;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= CFG_GAP;
    cfg_wdata <= {3'($urandom), gap};
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_gap  = gap;
  endtask

  // Receiver: stall pattern of its own, switching between free running,
  // light, medium and heavy stalling. Once, mid run, it holds off for a long
  // stretch so the output register fills and the input side stalls.
  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int p;
    int pick;
    logic [6:0] addr;
    logic [3:0] gap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain tick, spare action code as tick, then a write that the
    // target refuses at the address byte, with extreme index and data.
    send_slot(ACT_TICK, 8'h00, 8'h00, 1'b0);
    send_slot(ACT_SPARE, 8'hFF, 8'hFF, 1'b1);
    run_transfer(1'b0, 8'hFF, 8'h00, 8'h00, 0);
    drain_bus();

    // Random phases, each under its own address and gap setting. The first
    // two hit the register extremes, including a zero gap.
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       begin addr = 7'd127; gap = 4'd15; end
        1:       begin addr = 7'd0;   gap = 4'd0;  end
        2:       begin addr = 7'h55;  gap = 4'd1;  end
        3:       begin addr = 7'h2A;  gap = 4'd7;  end
        default: begin addr = 7'($urandom); gap = 4'($urandom_range(0, 5)); end
      endcase
      program_bus(addr, gap);
      while (slots_sent < 25 + 140 * (p + 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // well-formed transaction, one in four refused somewhere
          run_transfer(1'($urandom), pick_byte(), pick_byte(), pick_byte(),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : NO_NACK);
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 4))
            send_slot($urandom_range(0, 1) ? ACT_TICK : ACT_SPARE,
                      8'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          // junk slots break sequences anywhere; SDA-high ticks then NACK the
          // block back to idle so the next planned transaction lines up
          repeat ($urandom_range(3, 30))
            send_slot(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
          repeat (RESYNC_SLOTS) send_slot(ACT_TICK, 8'($urandom), 8'($urandom), 1'b1);
        end
      end
      drain_bus();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
